@@ rtl/fspa_pkg.sv @@
package fspa_pkg;

  // Pool geometry
  localparam int unsigned POOL_SLOTS     = 1024;
  localparam int unsigned MIN_ITEM_BYTES = 8;
  localparam int unsigned SLOT_W         = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W          = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SIZE_W         = 16;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SIZE      = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] req_size;
    logic [9:0]        free_slot;
  } fspa_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] slot;
  } fspa_rsp_t;

  // One entry of the link store
  typedef struct packed {
    logic              last;
    logic [SLOT_W-1:0] next;
  } fspa_link_t;

  // Write side of the link store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    fspa_link_t        data;
  } fspa_ram_wr_t;

  typedef enum logic {
    FSPA_IDLE,
    FSPA_EXEC
  } fspa_state_e;

endpackage

@@ rtl/fspa_link_ram.sv @@
module fspa_link_ram
  import fspa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output fspa_link_t        rd_data_o,
  input  fspa_ram_wr_t      wr_i
);

  fspa_link_t mem_q [POOL_SLOTS];
  fspa_link_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/fspa_ctrl.sv @@
module fspa_ctrl
  import fspa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fspa_req_t         req_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  output logic              result_valid_o,
  output fspa_rsp_t         rsp_o,
  output logic              rd_en_o,
  output logic [SLOT_W-1:0] rd_addr_o,
  input  fspa_link_t        rd_data_i,
  output fspa_ram_wr_t      wr_o
);

  fspa_state_e        state_q, state_d;
  fspa_req_t          req_q;
  logic [SIZE_W-1:0]  item_bytes_q, item_bytes_d;
  logic [SLOT_W-1:0]  head_q, head_d;
  logic               nonempty_q, nonempty_d;
  logic [CNT_W-1:0]   unused_q, unused_d;
  logic [CNT_W-1:0]   slots_cfg_q;
  fspa_rsp_t          rsp_q, rsp_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic               accept;
  logic               first_alloc;
  logic [CNT_W-1:0]   unused_eff;
  logic [CNT_W-1:0]   slots_sat;
  logic [SIZE_W-1:0]  size_fix;

  assign accept = start && !busy;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSPA_IDLE: if (accept) state_d = FSPA_EXEC;
      FSPA_EXEC: state_d = FSPA_IDLE;
      default:   state_d = FSPA_IDLE;
    endcase
  end

  // Outputs of the state machine; head link is fetched on every transfer
  always_comb begin
    busy      = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = head_q;
    case (state_q)
      FSPA_IDLE: rd_en_o = start;
      FSPA_EXEC: busy = 1'b1;
      default:   busy = 1'b0;
    endcase
  end

  // Values loaded by the first allocate
  assign first_alloc = (item_bytes_q == '0);
  assign slots_sat   = (slots_cfg_q > CNT_W'(POOL_SLOTS)) ? CNT_W'(POOL_SLOTS) : slots_cfg_q;
  assign size_fix    = (req_q.req_size > SIZE_W'(MIN_ITEM_BYTES)) ?
                       req_q.req_size : SIZE_W'(MIN_ITEM_BYTES);
  assign unused_eff  = first_alloc ? slots_sat : unused_q;

  // Request execution
  always_comb begin
    item_bytes_d = item_bytes_q;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    unused_d     = unused_q;
    rsp_d        = '{status: ST_OK, slot: '0};
    rsp_valid_d  = 1'b0;
    wr_o         = '{en: 1'b0, addr: req_q.free_slot[SLOT_W-1:0],
                     data: '{last: !nonempty_q, next: head_q}};
    if (state_q == FSPA_EXEC) begin
      rsp_valid_d = 1'b1;
      if (req_q.req_type == REQ_FREE) begin
        // push onto the free list, no double-free check
        if ({1'b0, req_q.free_slot} < 11'(POOL_SLOTS)) begin
          wr_o.en    = 1'b1;
          head_d     = req_q.free_slot[SLOT_W-1:0];
          nonempty_d = 1'b1;
        end
      end else if (!first_alloc && (item_bytes_q < req_q.req_size)) begin
        rsp_d.status = ST_SIZE;
      end else begin
        if (first_alloc) begin
          item_bytes_d = size_fix;
        end
        unused_d = unused_eff;
        if (nonempty_q) begin
          // pop: link of the head was read at the transfer
          rsp_d.slot = 10'(head_q);
          if (rd_data_i.last) begin
            nonempty_d = 1'b0;
          end else begin
            head_d = rd_data_i.next;
          end
        end else if (unused_eff != '0) begin
          unused_d   = unused_eff - CNT_W'(1);
          rsp_d.slot = 10'(unused_d);
        end else begin
          rsp_d.status = ST_EXHAUSTED;
        end
      end
    end
  end

  // Control and pool state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSPA_IDLE;
      item_bytes_q <= '0;
      head_q       <= '0;
      nonempty_q   <= 1'b0;
      unused_q     <= '0;
      slots_cfg_q  <= CNT_W'(POOL_SLOTS);
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      item_bytes_q <= item_bytes_d;
      head_q       <= head_d;
      nonempty_q   <= nonempty_d;
      unused_q     <= unused_d;
      rsp_valid_q  <= rsp_valid_d;
      if (cfg_we_i) begin
        slots_cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign result_valid_o = rsp_valid_q;
  assign rsp_o          = rsp_q;

endmodule

@@ rtl/fixed_slot_pool_allocator.sv @@
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------
// request   | start / busy               | req_i  (fspa_req_t)
// result    | result_valid_o, no stall   | rsp_o  (fspa_rsp_t)
// config    | cfg_we_i                   | cfg_wdata_i (slot count)
//
// A new request is taken only after the last one has executed: the transfer
// cycle reads the head's link from the registered link store, the next cycle executes and writes back.
// The result shows for one cycle, the cycle after execution.
// Reset is asynchronous; the link store needs no clearing, so requests are
// taken from the first cycle after reset. The receiver cannot stall.
module fixed_slot_pool_allocator
  import fspa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fspa_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic             result_valid_o,
  output fspa_rsp_t        rsp_o
);

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  fspa_link_t        rd_data;
  fspa_ram_wr_t      ram_wr;

  fspa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_o           (ram_wr)
  );

  fspa_link_ram u_link_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (ram_wr)
  );

endmodule

@@ rtl/fspa_checker.sv @@
module fspa_checker
  import fspa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      result_valid_o,
  input fspa_rsp_t rsp_o
);

  // a transfer locks out the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after transfer");

  // every transfer gives its result, registered after the execute state
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 result_valid_o)
    else $error("result missing after transfer");

  // no result without an earlier transfer
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without transfer");

  // status is a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_SIZE ||
                        rsp_o.status == ST_EXHAUSTED))
    else $error("undefined status");

  // failed allocations report slot zero
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && rsp_o.status != ST_OK |-> rsp_o.slot == '0)
    else $error("slot set on error");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

@@ sim/tb_fixed_slot_pool_allocator.sv @@
`timescale 1ns / 1ps

module tb_fixed_slot_pool_allocator;
  import fspa_pkg::*;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  fspa_req_t        req_i       = '0;
  logic             cfg_we_i    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i = '0;
  logic             result_valid_o;
  fspa_rsp_t        rsp_o;

  fixed_slot_pool_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Requests waiting to be driven, and replies still owed by the block
  fspa_req_t req_backlog[$];
  fspa_rsp_t due_grants[$];

  int unsigned send_gap_pct = 0;
  int unsigned bad_count    = 0;
  logic        xfer         = 1'b0;

  // Shadow of the allocator state
  logic [CNT_W-1:0]  count_reg = CNT_W'(POOL_SLOTS);
  logic [SIZE_W-1:0] item_sz   = '0;
  logic [SLOT_W-1:0] head      = '0;
  logic              has_free  = 1'b0;
  logic [CNT_W-1:0]  bump_left = '0;
  logic [SLOT_W-1:0] link_next [POOL_SLOTS];
  logic              link_end  [POOL_SLOTS];

  // Apply one request to the shadow state and give the reply it earns
  task automatic pool_step(input fspa_req_t r, output fspa_rsp_t o);
    logic [CNT_W-1:0] n;
    logic             go;
    o.status = ST_OK;
    o.slot   = '0;
    go       = 1'b1;
    if (r.req_type == REQ_FREE) begin
      // pushed without a double-free check, double frees included
      if (r.free_slot < POOL_SLOTS) begin
        link_next[r.free_slot] = head;
        link_end[r.free_slot]  = !has_free;
        head                   = r.free_slot;
        has_free               = 1'b1;
      end
    end else begin
      if (item_sz == '0) begin
        // first allocate fixes the item size and loads the bump count
        item_sz   = (r.req_size > SIZE_W'(MIN_ITEM_BYTES)) ? r.req_size
                                                           : SIZE_W'(MIN_ITEM_BYTES);
        n         = (count_reg > POOL_SLOTS) ? CNT_W'(POOL_SLOTS) : count_reg;
        bump_left = n;
      end else if (item_sz < r.req_size) begin
        o.status = ST_SIZE;
        go       = 1'b0;
      end
      if (go) begin
        if (has_free) begin
          o.slot = head;
          if (link_end[head]) begin
            has_free = 1'b0;
          end else begin
            head = link_next[head];
          end
        end else if (bump_left != '0) begin
          bump_left = bump_left - 1'b1;
          o.slot    = bump_left[SLOT_W-1:0];
        end else begin
          o.status = ST_EXHAUSTED;
        end
      end
    end
  endtask

  // Driver: present the next request once the current one has transferred
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || xfer) begin
      if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        start <= 1'b1;
        req_i <= req_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check replies, track register writes, predict on each transfer
  always @(posedge clk_i) begin : monitor
    fspa_rsp_t want;
    xfer <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_grants.size() == 0) begin
          $error("unexpected reply: status %0d slot %0d", rsp_o.status, rsp_o.slot);
          bad_count++;
        end else begin
          want = due_grants.pop_front();
          if (rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_o.status);
            bad_count++;
          end
          if (rsp_o.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp_o.slot);
            bad_count++;
          end
        end
      end
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (start && !busy) begin
        pool_step(req_i, want);
        due_grants.push_back(want);
      end
    end
  end

  // Stimulus helpers; fields a request ignores still carry random bits
  task automatic queue_alloc(input logic [SIZE_W-1:0] size);
    fspa_req_t r;
    r.req_type  = REQ_ALLOC;
    r.req_size  = size;
    r.free_slot = 10'($urandom_range(0, 1023));
    req_backlog.push_back(r);
  endtask

  task automatic queue_free(input logic [9:0] idx);
    fspa_req_t r;
    r.req_type  = REQ_FREE;
    r.req_size  = SIZE_W'($urandom_range(0, 65535));
    r.free_slot = idx;
    req_backlog.push_back(r);
  endtask

  // Wait until every request has transferred and every reply has come back
  task automatic drain();
    while (req_backlog.size() != 0 || start || due_grants.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned       pick, first_sz, span, alloc_pct;
    logic [CNT_W-1:0]  raw_cnt;
    logic [SIZE_W-1:0] gen_item;
    int unsigned       gap_plan [4];

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Pool size taken at the first allocate: small mostly, extremes sometimes
    pick = $urandom_range(0, 9);
    case (pick)
      0:       raw_cnt = '0;
      1:       raw_cnt = 11'd1;
      2:       raw_cnt = 11'd2047;
      3:       raw_cnt = CNT_W'(POOL_SLOTS);
      default: raw_cnt = CNT_W'($urandom_range(2, 48));
    endcase
    write_count(raw_cnt);
    span     = (raw_cnt > POOL_SLOTS) ? POOL_SLOTS : ((raw_cnt == 0) ? 16 : raw_cnt);
    first_sz = $urandom_range(0, 512);
    gen_item = (first_sz > MIN_ITEM_BYTES) ? SIZE_W'(first_sz) : SIZE_W'(MIN_ITEM_BYTES);

    // Directed: free before any allocate, size limits, double free, LIFO order
    queue_free(10'd1023);
    queue_alloc(SIZE_W'(first_sz));
    queue_alloc(16'hFFFF);
    queue_alloc(gen_item);
    queue_alloc(gen_item + 1'b1);
    queue_alloc('0);
    queue_free(10'd0);
    queue_free(10'd0);
    queue_alloc('0);
    queue_alloc('0);
    queue_free(10'd512);
    queue_alloc(gen_item);
    queue_free(10'd5);
    queue_free(10'd9);
    queue_alloc(16'd1);
    queue_alloc(16'd1);
    repeat (6) queue_alloc(SIZE_W'($urandom_range(0, gen_item)));
    drain();

    // Random phases: no gaps, heavy gaps, no gaps, light gaps
    gap_plan = '{0, 82, 0, 33};
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gap_plan[ph];
      for (int i = 0; i < 320; i++) begin
        if (i % 40 == 0) begin
          pick      = $urandom_range(0, 2);
          alloc_pct = (pick == 0) ? 25 : ((pick == 1) ? 55 : 85);
        end
        if ($urandom_range(0, 99) < alloc_pct) begin
          if ($urandom_range(0, 9) == 0)
            queue_alloc(SIZE_W'($urandom_range(0, 65535)));
          else
            queue_alloc(SIZE_W'($urandom_range(0, gen_item)));
        end else begin
          if ($urandom_range(0, 9) < 2)
            queue_free(10'($urandom_range(0, 1023)));
          else
            queue_free(10'($urandom_range(0, span - 1)));
        end
      end
      drain();
      // later writes must leave the pool alone
      case (ph)
        0:       write_count(11'd2047);
        1:       write_count('0);
        2:       write_count(11'd1);
        default: write_count(CNT_W'(POOL_SLOTS));
      endcase
    end
    drain();

    if (bad_count == 0) begin
      $display("tb_fixed_slot_pool_allocator OK");
    end else begin
      $display("tb_fixed_slot_pool_allocator NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb_fixed_slot_pool_allocator NOT OK");
    $finish;
  end

endmodule
